// ----- src/ac2b_pkg.sv -----
// Shared types and constants for the AVCC to Annex B converter.
package ac2b_pkg;

    // Input word: one buffer byte and the end-of-buffer mark.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       buffer_last;
    } t_in_word;

    // Output word: one result of the converter.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       frame_end;
        logic       malformed;
    } t_out_word;

    // Classified byte handed from the parser to the emitter.
    typedef struct packed {
        logic [7:0] data;
        logic       start;     // start code goes out before data
        logic       has_byte;  // data is a real output byte
        logic       last;      // closes the buffer
        logic       bad;       // buffer ended inside a prefix or payload
    } t_cmd;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LENGTH_SIZE = 2'd0;
    localparam logic [1:0] CFG_PASSTHROUGH = 2'd1;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 3;

    localparam logic [2:0] LEN_SIZE_MIN   = 3'd1;
    localparam logic [2:0] LEN_SIZE_MAX   = 3'd4;
    localparam logic [2:0] LEN_SIZE_RESET = 3'd4;

    // Entries in the queue between parser and emitter.
    localparam int unsigned QUEUE_DEPTH = 4;

endpackage

// ----- src/ac2b_front.sv -----
// Parser: tracks prefix and payload state and classifies each input byte.
module ac2b_front #(
    parameter int unsigned NAL_LEN_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [2:0]        i_length_size,
    input  logic              i_passthrough,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ac2b_pkg::t_in_word i_in_word,
    input  logic              i_full,
    output logic              o_push,
    output ac2b_pkg::t_cmd    o_cmd
);
    import ac2b_pkg::*;

    logic                    r_in_payload, n_in_payload;
    logic [1:0]              r_prefix_count, n_prefix_count;
    logic [NAL_LEN_BITS-1:0] r_nal_rem, n_nal_rem;
    logic                    r_start_pending, n_start_pending;

    logic       accept;
    logic [2:0] size;
    t_cmd       cmd;

    assign accept     = i_in_valid && !i_full;
    assign o_in_stall = i_full;

    // Clamp the prefix size into 1..4.
    always_comb begin
        size = i_length_size;
        if (i_length_size < LEN_SIZE_MIN) begin
            size = LEN_SIZE_MIN;
        end else if (i_length_size > LEN_SIZE_MAX) begin
            size = LEN_SIZE_MAX;
        end
    end

    always_comb begin
        n_in_payload    = r_in_payload;
        n_prefix_count  = r_prefix_count;
        n_nal_rem       = r_nal_rem;
        n_start_pending = r_start_pending;
        cmd.data        = i_in_word.in_byte;
        cmd.start       = 1'b0;
        cmd.has_byte    = 1'b0;
        cmd.last        = i_in_word.buffer_last;
        cmd.bad         = 1'b0;

        if (i_passthrough) begin
            cmd.has_byte = 1'b1;
        end else if (!r_in_payload) begin
            n_nal_rem = (r_nal_rem << 8) | NAL_LEN_BITS'(i_in_word.in_byte);
            if (({1'b0, r_prefix_count} + 3'd1) >= size) begin
                n_prefix_count = 2'd0;
                if (n_nal_rem != '0) begin
                    n_in_payload    = 1'b1;
                    n_start_pending = 1'b1;
                end
            end else begin
                n_prefix_count = r_prefix_count + 2'd1;
            end
        end else begin
            cmd.has_byte    = 1'b1;
            cmd.start       = r_start_pending;
            n_start_pending = 1'b0;
            n_nal_rem       = r_nal_rem - NAL_LEN_BITS'(1);
            if (n_nal_rem == '0) begin
                n_in_payload   = 1'b0;
                n_prefix_count = 2'd0;
            end
        end

        if (i_in_word.buffer_last) begin
            cmd.bad         = !i_passthrough && (n_in_payload || (n_prefix_count != 2'd0));
            n_in_payload    = 1'b0;
            n_prefix_count  = 2'd0;
            n_nal_rem       = '0;
            n_start_pending = 1'b0;
        end
    end

    // Drop bytes that produce no result.
    assign o_push = accept && (cmd.has_byte || cmd.last);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload    <= 1'b0;
            r_prefix_count  <= 2'd0;
            r_nal_rem       <= '0;
            r_start_pending <= 1'b0;
        end else if (accept) begin
            r_in_payload    <= n_in_payload;
            r_prefix_count  <= n_prefix_count;
            r_nal_rem       <= n_nal_rem;
            r_start_pending <= n_start_pending;
        end
    end

endmodule

// ----- src/ac2b_queue.sv -----
// Small register FIFO between parser and emitter.
module ac2b_queue #(
    parameter int unsigned WIDTH = 12,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ----- src/ac2b_back.sv -----
// Emitter: expands classified bytes into start code, payload and status words.
module ac2b_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ac2b_pkg::t_cmd      i_cmd,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ac2b_pkg::t_out_word o_out_word
);
    import ac2b_pkg::*;

    localparam logic [1:0] PH_ZERO_B = 2'd0;  // second start-code zero
    localparam logic [1:0] PH_ZERO_C = 2'd1;  // third start-code zero
    localparam logic [1:0] PH_ONE    = 2'd2;  // start-code 01
    localparam logic [1:0] PH_DATA   = 2'd3;  // payload byte

    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_ONE  = 8'h01;

    logic      r_out_valid, n_out_valid;
    t_out_word r_word, n_word;
    logic      r_busy, n_busy;
    logic [1:0] r_phase, n_phase;
    t_cmd      r_cmd, n_cmd;
    logic      load;

    function automatic t_out_word sc_word(input logic [7:0] b);
        t_out_word w;
        w.out_byte   = b;
        w.byte_valid = 1'b1;
        w.run_last   = 1'b0;
        w.frame_end  = 1'b0;
        w.malformed  = 1'b0;
        sc_word = w;
    endfunction

    // Closing word of one input byte: data or status only.
    function automatic t_out_word final_word(input t_cmd c);
        t_out_word w;
        w.out_byte   = c.has_byte ? c.data : 8'h00;
        w.byte_valid = c.has_byte;
        w.run_last   = 1'b1;
        w.frame_end  = c.last;
        w.malformed  = c.last && c.bad;
        final_word = w;
    endfunction

    assign load = !r_out_valid || !i_out_stall;

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_word      = r_word;
        n_busy      = r_busy;
        n_phase     = r_phase;
        n_cmd       = r_cmd;
        o_pop       = 1'b0;

        if (load) begin
            if (r_busy) begin
                n_out_valid = 1'b1;
                unique case (r_phase)
                    PH_ZERO_B: begin
                        n_word  = sc_word(SC_ZERO);
                        n_phase = PH_ZERO_C;
                    end
                    PH_ZERO_C: begin
                        n_word  = sc_word(SC_ZERO);
                        n_phase = PH_ONE;
                    end
                    PH_ONE: begin
                        n_word  = sc_word(SC_ONE);
                        n_phase = PH_DATA;
                    end
                    PH_DATA: begin
                        n_word = final_word(r_cmd);
                        n_busy = 1'b0;
                    end
                    default: begin
                        n_busy = 1'b0;
                    end
                endcase
            end else if (!i_empty) begin
                o_pop       = 1'b1;
                n_out_valid = 1'b1;
                if (i_cmd.start) begin
                    n_word  = sc_word(SC_ZERO);
                    n_busy  = 1'b1;
                    n_phase = PH_ZERO_B;
                    n_cmd   = i_cmd;
                end else begin
                    n_word = final_word(i_cmd);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word  <= n_word;
        r_cmd   <= n_cmd;
        r_phase <= n_phase;
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_busy      <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_busy      <= n_busy;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_word;

endmodule

// ----- src/avcc_to_annexb_nal_converter.sv -----
// Top level of the AVCC length-prefixed to Annex B start-code converter.
//
// Takes a decrypted H.264 buffer one byte per input word and rewrites each
// NAL unit from its big-endian length prefix (length_size bytes, 1 to 4; 0
// acts as 1 and 5..7 as 4) into the start code 00 00 00 01 followed by the
// payload. Zero-length NALs vanish. Each input byte gives zero to five output
// words; run_last marks the last word of an input byte, frame_end the word
// that closes the buffer, and malformed on that word flags a buffer that ended
// inside a prefix or payload (bytes already sent stand). A buffer-end byte that
// yields no data closes with a status-only word (byte_valid low). passthrough
// copies every byte unchanged. Throughput: one input word per cycle while
// o_in_stall is low; the output side is the limit at one word per cycle
// while i_out_stall is low, so each non-empty NAL adds four start-code words,
// and prefix bytes add none unless they close the buffer. A four-entry queue
// between parser and emitter absorbs those bursts and feeds the output
// register. Write the configuration registers only while the block is idle.
module avcc_to_annexb_nal_converter #(
    parameter int unsigned NAL_LEN_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [ac2b_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ac2b_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input byte channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  ac2b_pkg::t_in_word               i_in_word,
    // output word channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output ac2b_pkg::t_out_word              o_out_word
);
    import ac2b_pkg::*;

    logic [2:0] r_length_size;
    logic       r_passthrough;

    t_cmd front_cmd, queue_cmd;
    logic push, pop, full, empty;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length_size <= LEN_SIZE_RESET;
            r_passthrough <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LENGTH_SIZE: r_length_size <= i_cfg_data[2:0];
                CFG_PASSTHROUGH: r_passthrough <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Parse: classify each byte, hold prefix/payload state.
    ac2b_front #(
        .NAL_LEN_BITS (NAL_LEN_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_length_size (r_length_size),
        .i_passthrough (r_passthrough),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_word     (i_in_word),
        .i_full        (full),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    // Decouple parser from emitter.
    ac2b_queue #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .i_pop   (pop),
        .o_data  (queue_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    // Emit: expand start codes and drive the output register.
    ac2b_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_cmd),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

// ----- src/ac2b_checker.sv -----
// Port-level checks for the AVCC to Annex B converter, bound to the top level.
module ac2b_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input ac2b_pkg::t_out_word o_out_word
);
    import ac2b_pkg::*;

    // A stalled word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed under stall");

    // Reset empties the output register.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Buffer close is always the last word of its input byte.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.frame_end |-> o_out_word.run_last)
        else $error("frame_end without run_last");

    // Malformed only on the closing word.
    a_bad_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.malformed |-> o_out_word.frame_end)
        else $error("malformed outside frame_end");

    // A status-only word closes the buffer and carries a zero byte.
    a_status_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.byte_valid |->
            o_out_word.frame_end && (o_out_word.out_byte == 8'h00))
        else $error("bad status-only word");

endmodule

bind avcc_to_annexb_nal_converter ac2b_checker u_ac2b_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
